### rtl/ptlt_pkg.sv
package ptlt_pkg;

  localparam int NUM_PAGES = 64;
  localparam int PAGE_BITS = 6;
  localparam int FRAME_BITS = 8;
  localparam int LEN_BITS = 7;
  localparam int ADDR_BITS = 32;
  localparam int PADDR_BITS = 24;
  localparam int SHIFT_BITS = 5;
  localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 5'd12;
  localparam logic [SHIFT_BITS-1:0] SHIFT_MIN = 5'd4;
  localparam logic [SHIFT_BITS-1:0] SHIFT_MAX = 5'd16;

  typedef enum logic [2:0] {
    OP_TRANSLATE  = 3'd0,
    OP_QUERY      = 3'd1,
    OP_MAP        = 3'd2,
    OP_INVALIDATE = 3'd3,
    OP_SET_DIRTY  = 3'd4,
    OP_TOUCH      = 3'd5,
    OP_VICTIM     = 3'd6,
    OP_UNUSED     = 3'd7
  } opcode_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic                  present;
    logic                  valid;
    logic                  dirty;
    logic                  referenced;
  } pt_entry_t;

  typedef struct packed {
    logic            load;      // capture the input item
    logic            execute;   // perform the operation on the captured item
  } dp_cmd_t;

  typedef struct packed {
    logic            unused;
  } dp_status_t;

endpackage

### rtl/ptlt_if.sv
interface ptlt_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [31:0] virtual_addr;
  logic [5:0] page_number;
  logic [7:0] frame_number;
  modport source (output valid, opcode, virtual_addr, page_number, frame_number, input ready);
  modport sink (input valid, opcode, virtual_addr, page_number, frame_number, output ready);
endinterface

interface ptlt_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [23:0] physical_addr;
  logic [7:0]  entry_frame;
  logic        entry_dirty;
  logic        entry_referenced;
  logic [5:0]  victim_page;
  logic [31:0] fault_count;
  modport source (output valid, ok, physical_addr, entry_frame, entry_dirty,
                  entry_referenced, victim_page, fault_count, input ready);
  modport sink (input valid, ok, physical_addr, entry_frame, entry_dirty,
                entry_referenced, victim_page, fault_count, output ready);
endinterface

### rtl/ptlt_ctrl.sv
module ptlt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output ptlt_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // A result waiting in the output register blocks the next transaction;
  // the next item is captured in the cycle in which the result is taken.
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (out_ready) begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = S_EXEC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/ptlt_datapath.sv
module ptlt_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  ptlt_pkg::dp_cmd_t         cmd,
  input  logic [2:0]                opcode,
  input  logic [31:0]               virtual_addr,
  input  logic [5:0]                page_number,
  input  logic [7:0]                frame_number,
  input  logic [4:0]                page_size_log2,
  output logic                      ok,
  output logic [23:0]               physical_addr,
  output logic [7:0]                entry_frame,
  output logic                      entry_dirty,
  output logic                      entry_referenced,
  output logic [5:0]                victim_page,
  output logic [31:0]               fault_count
);

  localparam int N = ptlt_pkg::NUM_PAGES;
  localparam int PB = ptlt_pkg::PAGE_BITS;
  localparam int LB = ptlt_pkg::LEN_BITS;

  ptlt_pkg::opcode_t op_q;
  logic [31:0] vaddr_q;
  logic [PB-1:0] page_q;
  logic [7:0] frame_q;

  ptlt_pkg::pt_entry_t entries [N];
  logic [N-1:0] live;           // entry written since reset
  logic [PB-1:0] lru [N];       // positions in the list, LRU first
  logic [LB-1:0] lru_len;
  logic [LB-1:0] len_m1;
  logic [31:0] miss_cnt;

  logic [4:0] sh;
  logic [31:0] vpn_load;
  logic [PB-1:0] tpage_load;
  logic [31:0] vpn_full;
  logic [31:0] off;
  logic vpn_in;
  logic [PB-1:0] tpage;
  ptlt_pkg::pt_entry_t te;
  ptlt_pkg::pt_entry_t qe;
  logic hit;
  logic [63:0] paddr_w;
  logic do_touch;
  logic [PB-1:0] touch_page;
  logic [N-1:0] match;
  logic [N-1:0] shift_here;
  logic found;

  always_comb begin
    sh = page_size_log2;
    if (sh < ptlt_pkg::SHIFT_MIN) sh = ptlt_pkg::SHIFT_MIN;
    if (sh > ptlt_pkg::SHIFT_MAX) sh = ptlt_pkg::SHIFT_MAX;
  end

  assign vpn_load   = virtual_addr >> sh;
  assign tpage_load = vpn_load[PB-1:0];
  assign vpn_full   = vaddr_q >> sh;
  assign off        = vaddr_q & ((32'd1 << sh) - 32'd1);
  assign vpn_in     = (vpn_full < 32'(N));
  assign tpage      = vpn_full[PB-1:0];
  assign hit        = vpn_in && te.present && te.valid;
  assign paddr_w    = (64'(te.frame) << sh) | 64'(off);
  assign len_m1     = lru_len - LB'(1);

  always_comb begin
    do_touch   = 1'b0;
    touch_page = page_q;
    case (op_q)
      ptlt_pkg::OP_TRANSLATE: begin
        do_touch   = hit;
        touch_page = tpage;
      end
      ptlt_pkg::OP_MAP: do_touch = 1'b1;
      ptlt_pkg::OP_TOUCH: do_touch = qe.present;
      default: do_touch = 1'b0;
    endcase
  end

  // Each list slot compares itself with the page; slots at or after the
  // first match take their successor's value.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match[i] = (LB'(i) < lru_len) && (lru[i] == touch_page);
    end
    shift_here[0] = match[0];
    for (int i = 1; i < N; i++) begin
      shift_here[i] = shift_here[i-1] | match[i];
    end
    found = |match;
  end

  // The table is read while the item is captured, so the execute cycle
  // works from registered entries.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= ptlt_pkg::opcode_t'(opcode);
      vaddr_q <= virtual_addr;
      page_q  <= page_number;
      frame_q <= frame_number;
      te      <= live[tpage_load] ? entries[tpage_load] : '0;
      qe      <= live[page_number] ? entries[page_number] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live     <= '0;
      lru_len  <= '0;
      miss_cnt <= '0;
    end else if (cmd.execute) begin
      case (op_q)
        ptlt_pkg::OP_TRANSLATE: begin
          if (hit) begin
            entries[tpage].referenced <= 1'b1;
          end else if (miss_cnt != 32'hFFFF_FFFF) begin
            miss_cnt <= miss_cnt + 32'd1;
          end
        end
        ptlt_pkg::OP_MAP: begin
          entries[page_q] <= '{frame: frame_q, present: 1'b1, valid: 1'b1,
                               dirty: 1'b0, referenced: 1'b1};
          live[page_q] <= 1'b1;
        end
        ptlt_pkg::OP_INVALIDATE: begin
          if (qe.present) entries[page_q].valid <= 1'b0;
        end
        ptlt_pkg::OP_SET_DIRTY: begin
          if (qe.present) entries[page_q].dirty <= 1'b1;
        end
        ptlt_pkg::OP_TOUCH: begin
          if (qe.present) entries[page_q].referenced <= 1'b1;
        end
        ptlt_pkg::OP_VICTIM: begin
          if (lru_len != '0) begin
            for (int i = 0; i < N - 1; i++) lru[i] <= lru[i+1];
            lru_len <= lru_len - LB'(1);
          end
        end
        default: ;
      endcase
      if (do_touch) begin
        for (int i = 0; i < N - 1; i++) begin
          if (shift_here[i]) lru[i] <= lru[i+1];
        end
        if (found) begin
          lru[len_m1[PB-1:0]] <= touch_page;
        end else if (lru_len < LB'(N)) begin
          lru[lru_len[PB-1:0]] <= touch_page;
          lru_len <= lru_len + LB'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      ok               <= 1'b0;
      physical_addr    <= '0;
      entry_frame      <= '0;
      entry_dirty      <= 1'b0;
      entry_referenced <= 1'b0;
      victim_page      <= '0;
      case (op_q)
        ptlt_pkg::OP_TRANSLATE: begin
          ok            <= hit;
          physical_addr <= hit ? paddr_w[23:0] : '0;
        end
        ptlt_pkg::OP_QUERY: begin
          ok               <= qe.present && qe.valid;
          entry_frame      <= qe.frame;
          entry_dirty      <= qe.dirty;
          entry_referenced <= qe.referenced;
        end
        ptlt_pkg::OP_VICTIM: begin
          if (lru_len != '0) begin
            ok          <= 1'b1;
            victim_page <= lru[0];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    fault_count = miss_cnt;
  end

endmodule

### rtl/page_table_lru_translate.sv
// Channel | Direction | Payload
// in      | sink      | opcode, virtual_addr, page_number, frame_number
// out     | source    | ok, physical_addr, entry_*, victim_page, fault_count
// apb     | slave     | page_size_log2 at byte address 0
//
// Each transaction is a capture with the registered table read, then an
// execute step in which the parallel LRU compare-and-shift over 64 slots
// runs. The next item is accepted in the cycle its predecessor's result
// is taken. Reset is synchronous; no clearing pass is needed, entries have
// live bits. An output stall holds the result and the block accepts nothing more.
module page_table_lru_translate (
  input  logic        clk,
  input  logic        rst,
  ptlt_in_if.sink     in_ch,
  ptlt_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ptlt_pkg::dp_cmd_t cmd;
  logic [4:0] page_size_log2;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {27'd0, page_size_log2} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size_log2 <= ptlt_pkg::SHIFT_RESET;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      page_size_log2 <= pwdata[4:0];
    end
  end

  ptlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  ptlt_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .opcode           (in_ch.opcode),
    .virtual_addr     (in_ch.virtual_addr),
    .page_number      (in_ch.page_number),
    .frame_number     (in_ch.frame_number),
    .page_size_log2   (page_size_log2),
    .ok               (out_ch.ok),
    .physical_addr    (out_ch.physical_addr),
    .entry_frame      (out_ch.entry_frame),
    .entry_dirty      (out_ch.entry_dirty),
    .entry_referenced (out_ch.entry_referenced),
    .victim_page      (out_ch.victim_page),
    .fault_count      (out_ch.fault_count)
  );

  a_load_not_exec: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.execute)) else $error("load and execute together");
  a_exec_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.execute) else $error("captured item not executed");
  a_result_after_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> out_ch.valid) else $error("no result after execute");
  a_fault_monotone: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> out_ch.fault_count >= $past(out_ch.fault_count))
    else $error("fault count went down");

endmodule
